@@ rtl/core/rs_pkg.sv @@
// ----------------------------------------------------------------------------
// rs_pkg
// Types and constants shared by the reservation station modules.
// ----------------------------------------------------------------------------
package rs_pkg;

  typedef enum logic [1:0] {
    MODE_DISPATCH  = 2'd0,
    MODE_BROADCAST = 2'd1,
    MODE_ISSUE     = 2'd2,
    MODE_RETIRE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  localparam logic [6:0] TAG_READY = 7'h7F;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [5:0]  rob_id;
    logic [6:0]  tag_dest;
    logic [31:0] value_dest;
    logic [6:0]  tag_first;
    logic [31:0] value_first;
    logic [6:0]  tag_second;
    logic [31:0] value_second;
    logic [31:0] branch_pc;
    logic [31:0] broadcast_value;
    logic [1:0]  mode;
  } in_item_t;

  typedef struct packed {
    logic        issue_valid;
    logic [4:0]  out_opcode;
    logic [5:0]  out_rob_id;
    logic [31:0] out_dest;
    logic [31:0] out_first;
    logic [31:0] out_second;
    logic [31:0] out_branch_pc;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic        issued;
    logic [4:0]  opcode;
    logic [5:0]  rob;
    logic [6:0]  tag_dest;
    logic [6:0]  tag_first;
    logic [6:0]  tag_second;
    logic [31:0] val_dest;
    logic [31:0] val_first;
    logic [31:0] val_second;
    logic [31:0] pc;
  } entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic       load;       // take new entry
    logic       shift;      // take neighbor entry
    logic       bcast;      // wakeup
    logic       set_issued;
    logic [5:0] bc_id;
    logic [31:0] bc_val;
  } cell_ctl_t;

endpackage

@@ rtl/core/rs_if.sv @@
// ----------------------------------------------------------------------------
// rs_in_if / rs_out_if
// Valid/ready channels carrying station items.
// ----------------------------------------------------------------------------
interface rs_in_if;
  import rs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rs_out_if;
  import rs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/rs_cell.sv @@
// ----------------------------------------------------------------------------
// rs_cell
// One station slot: loads, shifts from its neighbor, marks itself issued, captures wakeups.
// ----------------------------------------------------------------------------
module rs_cell
  import rs_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    new_entry,
  input  entry_t    nbr_entry,
  output entry_t    entry,
  output logic      ready
);

  entry_t entry_r, entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load) begin
      entry_nxt = new_entry;
    end else if (ctl.shift) begin
      entry_nxt = nbr_entry;
    end else if (ctl.set_issued) begin
      entry_nxt.issued = 1'b1;
    end else if (ctl.bcast && !entry_r.issued) begin
      if (entry_r.tag_dest == {1'b0, ctl.bc_id}) begin
        entry_nxt.tag_dest = TAG_READY;
        entry_nxt.val_dest = ctl.bc_val;
      end
      if (entry_r.tag_first == {1'b0, ctl.bc_id}) begin
        entry_nxt.tag_first = TAG_READY;
        entry_nxt.val_first = ctl.bc_val;
      end
      if (entry_r.tag_second == {1'b0, ctl.bc_id}) begin
        entry_nxt.tag_second = TAG_READY;
        entry_nxt.val_second = ctl.bc_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign ready = !entry_r.issued && entry_r.tag_dest == TAG_READY &&
                 entry_r.tag_first == TAG_READY && entry_r.tag_second == TAG_READY;

endmodule

@@ rtl/core/reservation_station_top.sv @@
// ----------------------------------------------------------------------------
// reservation_station_top
// Age-ordered reservation station built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Each item is applied to the cell chain at the accept edge and its result
// lands in the output register, so a new item is taken every cycle while the
// output register is free or being drained. Dispatch, wakeup, issue (oldest
// ready) and retire (compacting shift) each complete in a single update of
// the cell row.
module reservation_station_top
  import rs_pkg::*;
#(
  parameter int STATION_DEPTH = 8,
  parameter int ID_COUNT      = 64
) (
  input  logic clk,
  input  logic rst_n,
  rs_in_if.sink     in_ch,
  rs_out_if.source  out_ch
);

  localparam int CW = $clog2(STATION_DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          ovalid_r;
  out_item_t     odata_r, odata_nxt;

  entry_t    cell_q [STATION_DEPTH];
  logic      cell_rdy [STATION_DEPTH];
  cell_ctl_t ctl [STATION_DEPTH];
  entry_t    new_e;
  in_item_t  it;
  logic      acc;

  logic [STATION_DEPTH-1:0] live, rdy_v, hit_v, iss_sel, ret_first, ret_after;

  assign it = in_ch.data;
  assign in_ch.ready = !ovalid_r || out_ch.ready;
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    new_e = '0;
    new_e.opcode = it.opcode;
    new_e.rob = it.rob_id;
    new_e.tag_dest = it.tag_dest;
    new_e.tag_first = it.tag_first;
    new_e.tag_second = it.tag_second;
    new_e.val_dest = it.value_dest;
    new_e.val_first = it.value_first;
    new_e.val_second = it.value_second;
    new_e.pc = it.branch_pc;
  end

  genvar g;
  generate
    for (g = 0; g < STATION_DEPTH; g++) begin : g_cell
      entry_t nbr;
      if (g + 1 < STATION_DEPTH) begin : g_n
        assign nbr = cell_q[g+1];
      end else begin : g_l
        assign nbr = cell_q[g];
      end
      assign live[g] = CW'(g) < count_r;
      assign rdy_v[g] = live[g] && cell_rdy[g];
      assign hit_v[g] = live[g] && ({2'b00, cell_q[g].rob} == 8'(it.rob_id)) &&
                        (32'(it.rob_id) < 32'(ID_COUNT));
      rs_cell u_cell (
        .clk(clk), .ctl(ctl[g]), .new_entry(new_e), .nbr_entry(nbr),
        .entry(cell_q[g]), .ready(cell_rdy[g])
      );
    end
  endgenerate

  always_comb begin
    iss_sel = rdy_v & (~rdy_v + 1'b1);
    ret_first = hit_v & (~hit_v + 1'b1);
    ret_after = ~((ret_first - 1'b1) | ret_first);
    if (ret_first == '0) ret_after = '0;
  end

  always_comb begin
    count_nxt = count_r;
    odata_nxt = '0;
    for (int i = 0; i < STATION_DEPTH; i++) begin
      ctl[i] = '0;
      ctl[i].bc_id = it.rob_id;
      ctl[i].bc_val = it.broadcast_value;
    end
    case (mode_t'(it.mode))
      MODE_DISPATCH: begin
        if (count_r >= CW'(STATION_DEPTH)) begin
          odata_nxt.status = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
          for (int i = 0; i < STATION_DEPTH; i++)
            ctl[i].load = acc && (CW'(i) == count_r);
        end
      end
      MODE_BROADCAST: begin
        for (int i = 0; i < STATION_DEPTH; i++)
          ctl[i].bcast = acc && live[i] && (32'(it.rob_id) < 32'(ID_COUNT));
      end
      MODE_ISSUE: begin
        for (int i = 0; i < STATION_DEPTH; i++) begin
          ctl[i].set_issued = acc && iss_sel[i];
          if (iss_sel[i]) begin
            odata_nxt.issue_valid = 1'b1;
            odata_nxt.out_opcode = cell_q[i].opcode;
            odata_nxt.out_rob_id = cell_q[i].rob;
            odata_nxt.out_dest = cell_q[i].val_dest;
            odata_nxt.out_first = cell_q[i].val_first;
            odata_nxt.out_second = cell_q[i].val_second;
            odata_nxt.out_branch_pc = cell_q[i].pc;
          end
        end
      end
      MODE_RETIRE: begin
        if (ret_first == '0) begin
          odata_nxt.status = ST_NOTFOUND;
        end else begin
          count_nxt = count_r - 1'b1;
          for (int i = 0; i < STATION_DEPTH; i++)
            ctl[i].shift = acc && (ret_first[i] || ret_after[i]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (acc) count_r <= count_nxt;
      if (acc) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) odata_r <= odata_nxt;
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data = odata_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STATION_DEPTH)) else $error("count overflow");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    acc && odata_nxt.status == ST_FULL |=> $stable(count_r)) else $error("full changed count");
  a_issue_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(iss_sel)) else $error("multiple issue");
  a_issue_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !odata_r.issue_valid |-> odata_r.out_branch_pc == '0)
    else $error("stale payload");

endmodule

@@ test/reservation_station_top_tb.sv @@
// ----------------------------------------------------------------------------
// reservation_station_top_tb
// Drives dispatch, wakeup, issue and retire items into the station, predicts
// each result with a local model of the entry store and checks every field.
// ----------------------------------------------------------------------------
module reservation_station_top_tb;
  import rs_pkg::*;

  localparam int DEPTH = 8;
  localparam int IDS   = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rs_in_if  in_ch ();
  rs_out_if out_ch ();

  reservation_station_top #(.STATION_DEPTH(DEPTH), .ID_COUNT(IDS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  entry_t    station [DEPTH];
  int        station_count;
  out_item_t expected_results [$];
  int        error_count;
  int        sent_count;
  int        issued_count;
  int        full_count;
  int        missing_count;
  bit        hold_off;
  int        stall_pct;
  int        burst_left;

  // model of the store, applied in accept order
  function automatic out_item_t station_step(in_item_t it);
    out_item_t r;
    logic [5:0] id;
    bit done;
    r = '0;
    id = it.rob_id;
    done = 1'b0;
    case (mode_t'(it.mode))
      MODE_DISPATCH: begin
        if (station_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          station[station_count].issued     = 1'b0;
          station[station_count].opcode     = it.opcode;
          station[station_count].rob        = it.rob_id;
          station[station_count].tag_dest   = it.tag_dest;
          station[station_count].tag_first  = it.tag_first;
          station[station_count].tag_second = it.tag_second;
          station[station_count].val_dest   = it.value_dest;
          station[station_count].val_first  = it.value_first;
          station[station_count].val_second = it.value_second;
          station[station_count].pc         = it.branch_pc;
          station_count++;
        end
      end
      MODE_BROADCAST: begin
        for (int i = 0; i < station_count; i++) begin
          if (!station[i].issued) begin
            if (station[i].tag_dest == {1'b0, id}) begin
              station[i].tag_dest = TAG_READY;
              station[i].val_dest = it.broadcast_value;
            end
            if (station[i].tag_first == {1'b0, id}) begin
              station[i].tag_first = TAG_READY;
              station[i].val_first = it.broadcast_value;
            end
            if (station[i].tag_second == {1'b0, id}) begin
              station[i].tag_second = TAG_READY;
              station[i].val_second = it.broadcast_value;
            end
          end
        end
      end
      MODE_ISSUE: begin
        for (int i = 0; i < station_count; i++) begin
          if (!done && !station[i].issued && station[i].tag_dest == TAG_READY &&
              station[i].tag_first == TAG_READY && station[i].tag_second == TAG_READY) begin
            station[i].issued = 1'b1;
            r.issue_valid   = 1'b1;
            r.out_opcode    = station[i].opcode;
            r.out_rob_id    = station[i].rob;
            r.out_dest      = station[i].val_dest;
            r.out_first     = station[i].val_first;
            r.out_second    = station[i].val_second;
            r.out_branch_pc = station[i].pc;
            done = 1'b1;
          end
        end
      end
      default: begin
        for (int i = 0; i < station_count; i++) begin
          if (!done && station[i].rob == id) begin
            for (int k = i; k + 1 < station_count; k++) station[k] = station[k + 1];
            station_count--;
            done = 1'b1;
          end
        end
        if (!done) r.status = ST_NOTFOUND;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  // checks each accepted result
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item", 32'(out_ch.data.status), 32'd0);
      end else begin
        out_item_t e;
        e = expected_results.pop_front();
        if (out_ch.data.issue_valid !== e.issue_valid)
          report_mismatch("issue_valid", 32'(out_ch.data.issue_valid), 32'(e.issue_valid));
        if (out_ch.data.out_opcode !== e.out_opcode)
          report_mismatch("opcode", 32'(out_ch.data.out_opcode), 32'(e.out_opcode));
        if (out_ch.data.out_rob_id !== e.out_rob_id)
          report_mismatch("rob_id", 32'(out_ch.data.out_rob_id), 32'(e.out_rob_id));
        if (out_ch.data.out_dest !== e.out_dest)
          report_mismatch("dest", out_ch.data.out_dest, e.out_dest);
        if (out_ch.data.out_first !== e.out_first)
          report_mismatch("first", out_ch.data.out_first, e.out_first);
        if (out_ch.data.out_second !== e.out_second)
          report_mismatch("second", out_ch.data.out_second, e.out_second);
        if (out_ch.data.out_branch_pc !== e.out_branch_pc)
          report_mismatch("branch_pc", out_ch.data.out_branch_pc, e.out_branch_pc);
        if (out_ch.data.status !== e.status)
          report_mismatch("status", 32'(out_ch.data.status), 32'(e.status));
      end
    end
  end

  // predicts at each accept edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      out_item_t r;
      r = station_step(in_ch.data);
      if (r.issue_valid) issued_count++;
      if (r.status == ST_FULL) full_count++;
      if (r.status == ST_NOTFOUND) missing_count++;
      expected_results = {expected_results, r};
      sent_count++;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(in_item_t it);
    if (burst_left == 0) begin
      int gap;
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(4);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [6:0] pick_tag();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return TAG_READY;
    if (sel == 9) return 7'($urandom_range(64, 126));
    return 7'($urandom_range(15));
  endfunction

  function automatic in_item_t make_item(mode_t m, logic [5:0] id);
    in_item_t it;
    it = '0;
    it.mode            = m;
    it.opcode          = 5'($urandom());
    it.rob_id          = id;
    it.tag_dest        = pick_tag();
    it.tag_first       = pick_tag();
    it.tag_second      = pick_tag();
    it.value_dest      = $urandom();
    it.value_first     = $urandom();
    it.value_second    = $urandom();
    it.branch_pc       = $urandom();
    it.broadcast_value = $urandom();
    return it;
  endfunction

  task automatic test_directed();
    in_item_t it;
    it = make_item(MODE_ISSUE, 6'd0);
    send_item(it);
    it = make_item(MODE_RETIRE, 6'd5);
    send_item(it);
    for (int i = 0; i < 9; i++) begin
      it = make_item(MODE_DISPATCH, (i == 8) ? 6'd63 : 6'(i));
      it.opcode     = (i[0]) ? 5'h1F : 5'h00;
      it.tag_dest   = (i == 1) ? 7'd63 : TAG_READY;
      it.tag_first  = (i == 2) ? 7'h40 : TAG_READY;
      it.tag_second = (i == 3) ? 7'd3 : TAG_READY;
      it.value_dest = (i[0]) ? 32'hFFFF_FFFF : 32'h8000_0000;
      it.branch_pc  = (i[0]) ? 32'hFFFF_FFFF : 32'h0;
      send_item(it);
    end
    it = make_item(MODE_BROADCAST, 6'd63);
    it.broadcast_value = 32'h7FFF_FFFF;
    send_item(it);
    it = make_item(MODE_BROADCAST, 6'd3);
    send_item(it);
    for (int i = 0; i < 9; i++) begin
      it = make_item(MODE_ISSUE, 6'd0);
      send_item(it);
    end
    it = make_item(MODE_RETIRE, 6'd0);
    send_item(it);
    it = make_item(MODE_RETIRE, 6'd2);
    send_item(it);
    go_idle();
    drain();
  endtask

  // dispatch with random content, mixed at random with wakeups, issues and retires; retires mostly name live ids
  task automatic test_random(int count);
    in_item_t it;
    int sel;
    logic [5:0] id;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      id = (station_count > 0 && $urandom_range(3) != 0) ?
           station[$urandom_range(station_count - 1)].rob : 6'($urandom_range(15));
      if (sel < 35)      it = make_item(MODE_DISPATCH, 6'($urandom_range(15)));
      else if (sel < 55) it = make_item(MODE_BROADCAST, 6'($urandom_range(15)));
      else if (sel < 75) it = make_item(MODE_ISSUE, id);
      else               it = make_item(MODE_RETIRE, (sel > 96) ? 6'($urandom()) : id);
      send_item(it);
    end
    go_idle();
  endtask

  task automatic test_backpressure();
    in_item_t it;
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 40; n++) begin
        it = make_item(mode_t'($urandom_range(3)), 6'($urandom_range(15)));
        send_item(it);
      end
    join
    go_idle();
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    station_count = 0;
    error_count = 0;
    hold_off = 1'b0;
    stall_pct = 30;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    stall_pct = 0;
    test_random(300);
    stall_pct = 50;
    test_random(400);
    drain();
    stall_pct = 20;
    test_random(400);
    drain();
    repeat (10) @(posedge clk);
    $display("%0d items: %0d issued, %0d refused full, %0d retire misses",
             sent_count, issued_count, full_count, missing_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ reservation_station_top.f @@
rtl/core/rs_pkg.sv
rtl/core/rs_if.sv
rtl/core/rs_cell.sv
rtl/core/reservation_station_top.sv
test/reservation_station_top_tb.sv
